// ----- design/drt_pkg.sv -----
package drt_pkg;

  localparam int unsigned MaxRegions = 16;
  localparam int unsigned IdxW       = $clog2(MaxRegions);
  localparam int unsigned CntW       = $clog2(MaxRegions + 1);

  typedef enum logic [2:0] {
    OcAppended = 3'd0,
    OcCovered  = 3'd1,
    OcReplaced = 3'd2,
    OcFull     = 3'd3,
    OcFlushed  = 3'd4,
    OcEmpty    = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } state_e;

  typedef enum logic {
    ModeMark  = 1'b0,
    ModeFlush = 1'b1
  } mode_e;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] w;
    logic [15:0] h;
  } rect_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
  } item_t;

  typedef struct packed {
    outcome_e    outcome;
    logic [15:0] out_x;
    logic [15:0] out_y;
    logic [15:0] out_w;
    logic [15:0] out_h;
    logic        last;
  } result_t;

  // both containment directions for one stored entry against the request
  typedef struct packed {
    logic entry_holds_req;
    logic req_holds_entry;
  } hold_t;

endpackage

// ----- design/dirty_rectangle_tracker.sv -----
// Dirty rectangle tracker. Holds an ordered table of up to 16 screen
// rectangles. A transaction is taken when start is high and busy is low.
// A mark (mode 0) returns one status result: table full, already covered
// by a stored entry, replaced a stored entry it covers, or appended. A
// flush (mode 1) returns every stored entry in order with last set on the
// final one, or a single empty result, and then clears the table. Results
// come out of a register: each is shown on result_o for exactly one cycle
// with result_valid_o high, and the receiver cannot hold them off, so it
// must take every strobed cycle. Sequencing: a mark on an empty or full
// table and a flush of an empty table are settled in the accept cycle and
// never raise busy. Otherwise the block stays busy while it visits the
// stored entries in order, since the single containment compare unit and
// the table's one registered read port handle one entry per cycle: a mark
// stops at the first hit or at the last stored entry; a flush visits every
// stored entry and streams one result per cycle. The first (or only)
// result appears the cycle after the entry it reports is examined.
module dirty_rectangle_tracker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  drt_pkg::item_t   item_i,
  output logic             result_valid_o,
  output drt_pkg::result_t result_o
);

  drt_pkg::state_e             state_q, state_d;
  logic [drt_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [drt_pkg::CntW-1:0]    count_q, count_d;
  drt_pkg::rect_t              req_q;
  drt_pkg::result_t            res_q, res_d;
  logic                        res_valid_q, emit;

  logic                        wr_en;
  logic [drt_pkg::IdxW-1:0]    wr_addr, rd_addr;
  drt_pkg::rect_t              wr_data, rd_data, in_rect;
  drt_pkg::hold_t              hold;
  logic                        accept, at_end;

  assign in_rect = '{x: item_i.rect_x, y: item_i.rect_y,
                     w: item_i.rect_w, h: item_i.rect_h};
  assign accept  = start && (state_q == drt_pkg::StIdle);
  // entry under compare is the last stored one
  assign at_end  = ({1'b0, idx_q} + drt_pkg::CntW'(1)) == count_q;

  drt_table u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  drt_contain u_contain (
    .entry_i (rd_data),
    .req_i   (req_q),
    .hold_o  (hold)
  );

  // Sequencer: read address runs one entry ahead of the compare.
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    count_d = count_q;
    wr_en   = 1'b0;
    wr_addr = count_q[drt_pkg::IdxW-1:0];
    wr_data = req_q;
    rd_addr = idx_q + drt_pkg::IdxW'(1);
    emit    = 1'b0;
    res_d   = '{outcome: drt_pkg::OcEmpty, out_x: '0, out_y: '0,
                out_w: '0, out_h: '0, last: 1'b1};

    case (state_q)
      drt_pkg::StIdle: begin
        rd_addr = '0;
        idx_d   = '0;
        if (accept) begin
          if (item_i.mode == drt_pkg::ModeFlush) begin
            if (count_q == '0) begin
              emit = 1'b1;
            end else begin
              state_d = drt_pkg::StFlush;
            end
          end else if (count_q >= drt_pkg::CntW'(drt_pkg::MaxRegions)) begin
            emit          = 1'b1;
            res_d.outcome = drt_pkg::OcFull;
          end else if (count_q == '0) begin
            // nothing to scan: append straight into slot 0
            wr_en         = 1'b1;
            wr_data       = in_rect;
            count_d       = drt_pkg::CntW'(1);
            emit          = 1'b1;
            res_d.outcome = drt_pkg::OcAppended;
            res_d.out_x   = in_rect.x;
            res_d.out_y   = in_rect.y;
            res_d.out_w   = in_rect.w;
            res_d.out_h   = in_rect.h;
          end else begin
            state_d = drt_pkg::StScan;
          end
        end
      end

      drt_pkg::StScan: begin
        idx_d = idx_q + drt_pkg::IdxW'(1);
        if (hold.entry_holds_req) begin
          emit          = 1'b1;
          res_d.outcome = drt_pkg::OcCovered;
          res_d.out_x   = rd_data.x;
          res_d.out_y   = rd_data.y;
          res_d.out_w   = rd_data.w;
          res_d.out_h   = rd_data.h;
          state_d       = drt_pkg::StIdle;
        end else if (hold.req_holds_entry || at_end) begin
          wr_en         = 1'b1;
          emit          = 1'b1;
          res_d.outcome = drt_pkg::OcAppended;
          res_d.out_x   = req_q.x;
          res_d.out_y   = req_q.y;
          res_d.out_w   = req_q.w;
          res_d.out_h   = req_q.h;
          state_d       = drt_pkg::StIdle;
          if (hold.req_holds_entry) begin
            wr_addr       = idx_q;
            res_d.outcome = drt_pkg::OcReplaced;
          end else begin
            count_d = count_q + drt_pkg::CntW'(1);
          end
        end
      end

      drt_pkg::StFlush: begin
        idx_d         = idx_q + drt_pkg::IdxW'(1);
        emit          = 1'b1;
        res_d.outcome = drt_pkg::OcFlushed;
        res_d.out_x   = rd_data.x;
        res_d.out_y   = rd_data.y;
        res_d.out_w   = rd_data.w;
        res_d.out_h   = rd_data.h;
        res_d.last    = at_end;
        if (at_end) begin
          count_d = '0;
          state_d = drt_pkg::StIdle;
        end
      end

      default: begin
        state_d = drt_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drt_pkg::StIdle;
      idx_q       <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      res_valid_q <= emit;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_rect;
    end
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign busy           = (state_q != drt_pkg::StIdle);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= drt_pkg::CntW'(drt_pkg::MaxRegions))
    else $error("entry count beyond table size");

  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy dropped without a result");

  a_flush_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |=> result_valid_o)
    else $error("flush stream broken");

  a_notlast_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> result_o.outcome == drt_pkg::OcFlushed)
    else $error("non-final result that is not a flushed entry");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (item_i.mode == drt_pkg::ModeMark) &&
    (count_q == drt_pkg::CntW'(drt_pkg::MaxRegions))
    |=> result_valid_o && (result_o.outcome == drt_pkg::OcFull) &&
        $stable(count_q))
    else $error("mark on full table not refused");
`endif

endmodule

// ----- design/drt_table.sv -----
module drt_table (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [drt_pkg::IdxW-1:0] wr_addr_i,
  input  drt_pkg::rect_t           wr_data_i,
  input  logic [drt_pkg::IdxW-1:0] rd_addr_i,
  output drt_pkg::rect_t           rd_data_o
);

  drt_pkg::rect_t mem_q [drt_pkg::MaxRegions];
  drt_pkg::rect_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- design/drt_contain.sv -----
module drt_contain (
  input  drt_pkg::rect_t entry_i,
  input  drt_pkg::rect_t req_i,
  output drt_pkg::hold_t hold_o
);

  // 17-bit edge sums, never wrap
  logic [16:0] e_right, e_bottom, r_right, r_bottom;

  assign e_right  = {1'b0, entry_i.x} + {1'b0, entry_i.w};
  assign e_bottom = {1'b0, entry_i.y} + {1'b0, entry_i.h};
  assign r_right  = {1'b0, req_i.x} + {1'b0, req_i.w};
  assign r_bottom = {1'b0, req_i.y} + {1'b0, req_i.h};

  assign hold_o.entry_holds_req = (entry_i.x <= req_i.x) && (entry_i.y <= req_i.y) &&
                                  (e_right >= r_right) && (e_bottom >= r_bottom);
  assign hold_o.req_holds_entry = (req_i.x <= entry_i.x) && (req_i.y <= entry_i.y) &&
                                  (r_right >= e_right) && (r_bottom >= e_bottom);

endmodule

// ----- tb/tb_dirty_rectangle_tracker.sv -----
module tb_dirty_rectangle_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest run is roughly 160 transactions, each a full table scan plus the longest idle gap, far below this.
  localparam int unsigned CycleLimit = 200000;

  // Scoreboard: keeps its own copy of the region table, queues the
  // results each accepted transaction should produce and checks them in order.
  class region_scoreboard;
    drt_pkg::rect_t   regions [drt_pkg::MaxRegions];
    int unsigned      count;
    drt_pkg::result_t expected_q [$];
    int unsigned      errors;

    function new();
      count  = 0;
      errors = 0;
    endfunction

    // Inclusive containment, right and bottom edges formed at 17 bits.
    function bit holds(drt_pkg::rect_t outer, drt_pkg::rect_t inner);
      logic [16:0] o_right, o_bottom, i_right, i_bottom;
      o_right  = {1'b0, outer.x} + {1'b0, outer.w};
      o_bottom = {1'b0, outer.y} + {1'b0, outer.h};
      i_right  = {1'b0, inner.x} + {1'b0, inner.w};
      i_bottom = {1'b0, inner.y} + {1'b0, inner.h};
      return outer.x <= inner.x && outer.y <= inner.y &&
             o_right >= i_right && o_bottom >= i_bottom;
    endfunction

    function void push(drt_pkg::outcome_e oc, drt_pkg::rect_t r, logic last);
      drt_pkg::result_t res;
      res.outcome = oc;
      res.out_x   = r.x;
      res.out_y   = r.y;
      res.out_w   = r.w;
      res.out_h   = r.h;
      res.last    = last;
      expected_q.push_back(res);
    endfunction

    function void note_item(drt_pkg::item_t it);
      drt_pkg::rect_t req;
      req = '{x: it.rect_x, y: it.rect_y, w: it.rect_w, h: it.rect_h};
      if (it.mode == drt_pkg::ModeFlush) begin
        if (count == 0) begin
          push(drt_pkg::OcEmpty, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < count; i++)
            push(drt_pkg::OcFlushed, regions[i], i + 1 == count);
          count = 0;
        end
        return;
      end
      if (count >= drt_pkg::MaxRegions) begin
        push(drt_pkg::OcFull, '0, 1'b1);
        return;
      end
      // first hit in table order wins, covered checked before replaced
      for (int unsigned i = 0; i < count; i++) begin
        if (holds(regions[i], req)) begin
          push(drt_pkg::OcCovered, regions[i], 1'b1);
          return;
        end
        if (holds(req, regions[i])) begin
          regions[i] = req;
          push(drt_pkg::OcReplaced, req, 1'b1);
          return;
        end
      end
      regions[count] = req;
      count++;
      push(drt_pkg::OcAppended, req, 1'b1);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(drt_pkg::result_t got);
      drt_pkg::result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result outcome=%0d x=%h y=%h w=%h h=%h last=%b",
                         got.outcome, got.out_x, got.out_y, got.out_w, got.out_h,
                         got.last));
        return;
      end
      exp = expected_q.pop_front();
      if (got.outcome !== exp.outcome || got.out_x !== exp.out_x ||
          got.out_y !== exp.out_y || got.out_w !== exp.out_w ||
          got.out_h !== exp.out_h || got.last !== exp.last)
        report($sformatf("got oc=%0d %h/%h/%h/%h last=%b, want oc=%0d %h/%h/%h/%h last=%b",
                         got.outcome, got.out_x, got.out_y, got.out_w, got.out_h,
                         got.last, exp.outcome, exp.out_x, exp.out_y, exp.out_w,
                         exp.out_h, exp.last));
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  drt_pkg::item_t   item_i;
  logic             result_valid_o;
  drt_pkg::result_t result_o;

  region_scoreboard sb;
  int unsigned      cycle_cnt;
  bit               no_gaps;   // set during back-to-back stretches

  dirty_rectangle_tracker dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Results cannot be held off: every strobed cycle is a result to check.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result(result_o);
  end

  // Watchdog: also catches expectations that never arrive.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic drt_pkg::item_t mark(logic [15:0] x, logic [15:0] y,
                                          logic [15:0] w, logic [15:0] h);
    drt_pkg::item_t it;
    it.mode   = drt_pkg::ModeMark;
    it.rect_x = x;
    it.rect_y = y;
    it.rect_w = w;
    it.rect_h = h;
    return it;
  endfunction

  // Flush carries junk in the rectangle fields; the block must ignore it.
  function automatic drt_pkg::item_t flush_item();
    drt_pkg::item_t it;
    it      = mark(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    it.mode = drt_pkg::ModeFlush;
    return it;
  endfunction

  // Present one transaction and hold it until the block takes it.
  task automatic send_item(drt_pkg::item_t it);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(it);
  endtask

  // Mostly no gap or a short one, occasionally a long stall.
  task automatic idle_gap();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 90)       n = $urandom_range(1, 3);
    else                   n = $urandom_range(8, 40);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Rectangle mix: variants of stored entries (covered / replaced hits),
  // a tiny grid where containment is frequent, full-range values, and
  // rectangles whose edges run past 16 bits.
  function automatic drt_pkg::rect_t random_rect();
    drt_pkg::rect_t r;
    int unsigned    pick;
    pick = $urandom_range(0, 99);
    if (pick < 30 && sb.count != 0) begin
      r = sb.regions[$urandom_range(0, sb.count - 1)];
      case ($urandom_range(0, 2))
        0: begin
          if (r.w >= 2) begin r.x += 16'd1; r.w -= 16'd2; end
          if (r.h >= 2) begin r.y += 16'd1; r.h -= 16'd2; end
        end
        1: begin
          if (r.x != 0) begin r.x -= 16'd1; r.w += 16'(r.w != 16'hffff); end
          if (r.y != 0) begin r.y -= 16'd1; r.h += 16'(r.h != 16'hffff); end
          if (r.w < 16'hfffe) r.w += 16'd1;
        end
        default: ;
      endcase
    end else if (pick < 65) begin
      r = '{x: 16'($urandom_range(0, 15)), y: 16'($urandom_range(0, 15)),
            w: 16'($urandom_range(0, 15)), h: 16'($urandom_range(0, 15))};
    end else if (pick < 85) begin
      r = '{x: 16'($urandom), y: 16'($urandom), w: 16'($urandom), h: 16'($urandom)};
    end else begin
      r = '{x: 16'($urandom_range(65000, 65535)), y: 16'($urandom_range(65000, 65535)),
            w: 16'($urandom_range(60000, 65535)), h: 16'($urandom_range(60000, 65535))};
    end
    return r;
  endfunction

  initial begin
    drt_pkg::rect_t r;
    sb        = new();
    cycle_cnt = 0;
    no_gaps   = 1'b0;
    rst_ni    <= 1'b0;
    start     <= 1'b0;
    item_i    <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    send_item(flush_item());                                 // flush of empty table
    idle_gap();
    send_item(mark(16'h0000, 16'h0000, 16'h0000, 16'h0000)); // zero-size append
    send_item(mark(16'h0000, 16'h0000, 16'h0000, 16'h0000)); // identical: covered
    idle_gap();
    send_item(mark(16'hffff, 16'hffff, 16'hffff, 16'hffff)); // max edges, 17-bit sums
    send_item(mark(16'h0000, 16'h0000, 16'hffff, 16'hffff)); // replaces the zero entry
    idle_gap();
    send_item(mark(16'h0001, 16'h0001, 16'h0005, 16'h0005)); // covered by entry 0
    send_item(flush_item());                                 // two entries out
    idle_gap();
    // staircase: x rises while y falls, so no entry contains another
    for (int unsigned i = 0; i < drt_pkg::MaxRegions; i++) begin
      send_item(mark(16'(i * 16'h1000), 16'(16'hffff - i * 16'h1000),
                     16'($urandom_range(0, 16'h0fff)),
                     16'($urandom_range(0, 16'h0fff))));
      idle_gap();
    end
    send_item(mark(16'h8000, 16'h8000, 16'h0001, 16'h0001)); // table full
    send_item(flush_item());                                 // sixteen entries out
    idle_gap();

    // --- random part ---
    for (int unsigned n = 0; n < 135; n++) begin
      if (n % 20 == 0)
        no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 7) begin
        send_item(flush_item());
      end else begin
        r = random_rect();
        send_item(mark(r.x, r.y, r.w, r.h));
      end
      idle_gap();
    end
    // leave the table empty so the last scan runs to completion
    send_item(flush_item());
    start <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    // catch stray strobes after the last expected result
    repeat (drt_pkg::MaxRegions + 4) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/drt_pkg.sv
design/drt_table.sv
design/drt_contain.sv
design/dirty_rectangle_tracker.sv
tb/tb_dirty_rectangle_tracker.sv
